>>> rtl/core/ffsp_pkg.sv
package ffsp_pkg;

  // Table sizes and id width.
  localparam int MaxServers = 16;
  localparam int MaxClients = 16;
  localparam int IdBits     = 16;

  localparam int SrvIdxW   = $clog2(MaxServers);
  localparam int SrvCntW   = $clog2(MaxServers + 1);
  localparam int CliCntW   = $clog2(MaxClients + 1);
  localparam int MinLevels = $clog2(MaxServers);
  localparam int MinSpan   = 1 << MinLevels;
  localparam int LvlW      = $clog2(MinLevels + 1);

  // Cycles from an accepted word to the cycle in which its result strobe is sampled.
  localparam int Latency = MinLevels + 3;

  // Operation codes.
  localparam logic [2:0] OpAddClient = 3'd0;
  localparam logic [2:0] OpAddServer = 3'd1;
  localparam logic [2:0] OpDelete    = 3'd2;
  localparam logic [2:0] OpDispatch  = 3'd3;
  localparam logic [2:0] OpGetPeer   = 3'd4;

  // Status codes.
  localparam logic [1:0] StatusDone = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusDup  = 2'd2;

  typedef logic [IdBits-1:0]  id_t;
  typedef logic [SrvIdxW-1:0] srv_idx_t;
  typedef logic [SrvCntW-1:0] srv_cnt_t;
  typedef logic [CliCntW-1:0] cli_cnt_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] member_id;
  } req_t;

  typedef struct packed {
    logic [15:0] peer_id;
    logic [1:0]  status;
    logic [4:0]  server_count;
    logic [4:0]  client_count;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_REDUCE,
    S_APPLY
  } state_e;

  // Contents of one server slot.
  typedef struct packed {
    id_t  id;
    logic paired;
    id_t  partner;
  } srv_slot_t;

  // Per-cycle commands to one server cell.
  typedef struct packed {
    logic load;
    logic shift;
    logic set_pair;
    logic drop;
  } srv_ctl_t;

  // Compare results of one server cell against the key.
  typedef struct packed {
    logic hit;
    logic part_hit;
    logic free;
  } srv_flags_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cli_ctl_t;

  // One entry of the lowest-id search.
  typedef struct packed {
    logic     val;
    id_t      id;
    srv_idx_t idx;
  } min_ent_t;

endpackage

>>> rtl/core/ffsp_srv_cell.sv
module ffsp_srv_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ffsp_pkg::id_t          key_i,
  input  logic                   valid_i,
  input  ffsp_pkg::srv_ctl_t     ctl_i,
  input  ffsp_pkg::srv_slot_t    nbr_i,
  output ffsp_pkg::srv_slot_t    slot_o,
  output ffsp_pkg::srv_flags_t   flags_o
);
  import ffsp_pkg::*;

  id_t  id_q, id_d;
  id_t  partner_q, partner_d;
  logic paired_q, paired_d;

  // The outgoing view already has a dropped pairing removed, so a shifting
  // neighbor picks up the cleared bit.
  always_comb begin
    slot_o.id      = id_q;
    slot_o.paired  = paired_q & ~ctl_i.drop;
    slot_o.partner = partner_q;
  end

  always_comb begin
    flags_o.hit      = valid_i && (id_q == key_i);
    flags_o.part_hit = valid_i && paired_q && (partner_q == key_i);
    flags_o.free     = valid_i && !paired_q;
  end

  always_comb begin
    id_d      = id_q;
    partner_d = partner_q;
    paired_d  = paired_q & ~ctl_i.drop;
    if (ctl_i.load) begin
      id_d      = key_i;
      paired_d  = 1'b0;
      partner_d = '0;
    end else if (ctl_i.shift) begin
      id_d      = nbr_i.id;
      paired_d  = nbr_i.paired;
      partner_d = nbr_i.partner;
    end else if (ctl_i.set_pair) begin
      paired_d  = 1'b1;
      partner_d = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paired_q <= 1'b0;
    end else begin
      paired_q <= paired_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q      <= id_d;
    partner_q <= partner_d;
  end

endmodule

>>> rtl/core/ffsp_cli_cell.sv
module ffsp_cli_cell (
  input  logic               clk_i,
  input  ffsp_pkg::id_t      key_i,
  input  logic               valid_i,
  input  ffsp_pkg::cli_ctl_t ctl_i,
  input  ffsp_pkg::id_t      nbr_i,
  output ffsp_pkg::id_t      id_o,
  output logic               hit_o
);
  import ffsp_pkg::*;

  id_t id_q, id_d;

  assign id_o  = id_q;
  assign hit_o = valid_i && (id_q == key_i);

  always_comb begin
    id_d = id_q;
    if (ctl_i.load) begin
      id_d = key_i;
    end else if (ctl_i.shift) begin
      id_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule

>>> rtl/core/ffsp_min_tree.sv
module ffsp_min_tree (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic                                step_i,
  input  logic [ffsp_pkg::MaxServers-1:0]     cand_i,
  input  ffsp_pkg::id_t                       ids_i [ffsp_pkg::MaxServers],
  output ffsp_pkg::min_ent_t                  best_o
);
  import ffsp_pkg::*;

  min_ent_t ent_q [MinSpan];
  min_ent_t ent_d [MinSpan];

  function automatic min_ent_t pick(input min_ent_t a, input min_ent_t b);
    if (a.val && (!b.val || (a.id < b.id))) begin
      return a;
    end
    return b;
  endfunction

  // Each step halves the field of candidates; the winner ends in entry 0.
  always_comb begin
    ent_d = ent_q;
    if (load_i) begin
      for (int j = 0; j < MinSpan; j++) begin
        if (j < MaxServers) begin
          ent_d[j].val = cand_i[j];
          ent_d[j].id  = ids_i[j];
          ent_d[j].idx = SrvIdxW'(j);
        end else begin
          ent_d[j].val = 1'b0;
          ent_d[j].id  = '0;
          ent_d[j].idx = '0;
        end
      end
    end else if (step_i) begin
      for (int j = 0; j < MinSpan / 2; j++) begin
        ent_d[j] = pick(ent_q[2*j], ent_q[2*j+1]);
      end
      for (int j = MinSpan / 2; j < MinSpan; j++) begin
        ent_d[j].val = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign best_o = ent_q[0];

endmodule

>>> rtl/core/first_free_server_pairing_table_top.sv
// Server and client pairing table.
//
// The table holds servers in order of arrival and a list of clients. A
// command word (op, member_id) is taken at a rising clock edge at which start
// is high and busy is low. The block then works on that word alone and
// answers with one result word on res_o, marked by valid_o for exactly one
// cycle; the receiver cannot hold it off and must take it in that cycle.
//
// Each word passes from acceptance to the edge at which its result is taken
// through these states in order: a match state in which every cell compares
// its entry with the id, a reduce state in which the lowest-id search halves
// its field of candidates step by step, an apply state in which the cells
// shift, load or pair and the result is registered, and the idle state that
// shows the result. busy drops in the cycle that shows the result, so a new
// word may be accepted there, and the block takes no new word until the
// result of the last one is shown.
//
// Reset empties both lists and clears every pairing; the table is ready to
// take a word in the first cycle after reset is released.
module first_free_server_pairing_table_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  ffsp_pkg::req_t   req_i,
  output logic             busy,
  output logic             valid_o,
  output ffsp_pkg::res_t   res_o
);
  import ffsp_pkg::*;

  state_e   state_q, state_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [2:0] op_q;
  id_t      key_q;
  srv_cnt_t srv_cnt_q, srv_cnt_d;
  cli_cnt_t cli_cnt_q, cli_cnt_d;
  logic     valid_q;
  res_t     res_q;

  logic load_min, step_min;

  // Cell array wiring.
  srv_slot_t  srv_slot [MaxServers];
  srv_slot_t  srv_nbr  [MaxServers];
  srv_ctl_t   srv_ctl  [MaxServers];
  srv_flags_t srv_flag [MaxServers];
  id_t        srv_ids  [MaxServers];
  cli_ctl_t   cli_ctl  [MaxClients];
  id_t        cli_id   [MaxClients];
  id_t        cli_nbr  [MaxClients];

  logic [MaxServers-1:0] srv_valid, srv_hit, part_hit, srv_free;
  logic [MaxClients-1:0] cli_valid, cli_hit;

  // Compare results captured in the match cycle.
  logic [MaxServers-1:0] srv_hit_q, free_q;
  logic [MaxClients-1:0] cli_hit_q;

  logic [MaxServers-1:0] cand;
  min_ent_t              best;

  // The server cells form a chain; on a delete each cell from the removed
  // slot upward takes the contents of the cell above it.
  for (genvar k = 0; k < MaxServers; k++) begin : g_srv
    assign srv_valid[k] = SrvCntW'(k) < srv_cnt_q;
    if (k == MaxServers - 1) begin : g_end
      assign srv_nbr[k] = '0;
    end else begin : g_mid
      assign srv_nbr[k] = srv_slot[k+1];
    end

    ffsp_srv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .valid_i (srv_valid[k]),
      .ctl_i   (srv_ctl[k]),
      .nbr_i   (srv_nbr[k]),
      .slot_o  (srv_slot[k]),
      .flags_o (srv_flag[k])
    );

    assign srv_hit[k]  = srv_flag[k].hit;
    assign part_hit[k] = srv_flag[k].part_hit;
    assign srv_free[k] = srv_flag[k].free;
    assign srv_ids[k]  = srv_slot[k].id;
  end

  for (genvar k = 0; k < MaxClients; k++) begin : g_cli
    assign cli_valid[k] = CliCntW'(k) < cli_cnt_q;
    if (k == MaxClients - 1) begin : g_end
      assign cli_nbr[k] = '0;
    end else begin : g_mid
      assign cli_nbr[k] = cli_id[k+1];
    end

    ffsp_cli_cell u_cell (
      .clk_i   (clk_i),
      .key_i   (key_q),
      .valid_i (cli_valid[k]),
      .ctl_i   (cli_ctl[k]),
      .nbr_i   (cli_nbr[k]),
      .id_o    (cli_id[k]),
      .hit_o   (cli_hit[k])
    );
  end

  // On a delete, the server being removed does not count as a partner
  // holder, since the pairing is dropped after that server is gone.
  assign cand = part_hit & ~((op_q == OpDelete) ? srv_hit : '0);

  ffsp_min_tree u_min (
    .clk_i  (clk_i),
    .load_i (load_min),
    .step_i (step_min),
    .cand_i (cand),
    .ids_i  (srv_ids),
    .best_o (best)
  );

  // Sequencer: match, then the search steps, then the update.
  always_comb begin
    state_d  = state_q;
    lvl_d    = lvl_q;
    load_min = 1'b0;
    step_min = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        load_min = 1'b1;
        lvl_d    = '0;
        state_d  = S_REDUCE;
      end
      S_REDUCE: begin
        step_min = 1'b1;
        lvl_d    = lvl_q + LvlW'(1);
        if (lvl_q == LvlW'(MinLevels - 1)) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Update of the cells and the answer, used in the apply cycle.
  logic [MaxServers-1:0] srv_first, free_first, srv_tail;
  logic [MaxClients-1:0] cli_tail;
  logic                  srv_any, cli_any, free_any, own_paired, srv_full, cli_full;
  logic                  srv_acc, cli_acc;
  id_t                   disp_id, own_partner, peer;
  logic [1:0]            status;

  always_comb begin
    srv_first  = srv_hit_q & (~srv_hit_q + MaxServers'(1));
    free_first = free_q & (~free_q + MaxServers'(1));
    srv_any    = |srv_hit_q;
    cli_any    = |cli_hit_q;
    free_any   = |free_q;
    srv_full   = srv_cnt_q == SrvCntW'(MaxServers);
    cli_full   = cli_cnt_q == CliCntW'(MaxClients);

    // Every cell at or above the matching one takes part in a removal.
    srv_acc = 1'b0;
    for (int k = 0; k < MaxServers; k++) begin
      srv_acc     = srv_acc | srv_hit_q[k];
      srv_tail[k] = srv_acc;
    end
    cli_acc = 1'b0;
    for (int k = 0; k < MaxClients; k++) begin
      cli_acc     = cli_acc | cli_hit_q[k];
      cli_tail[k] = cli_acc;
    end

    disp_id     = '0;
    own_partner = '0;
    own_paired  = 1'b0;
    for (int k = 0; k < MaxServers; k++) begin
      if (free_first[k]) begin
        disp_id = disp_id | srv_slot[k].id;
      end
      if (srv_first[k] && srv_slot[k].paired) begin
        own_partner = own_partner | srv_slot[k].partner;
        own_paired  = 1'b1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MaxServers; k++) begin
      srv_ctl[k] = '0;
    end
    for (int k = 0; k < MaxClients; k++) begin
      cli_ctl[k] = '0;
    end
    srv_cnt_d = srv_cnt_q;
    cli_cnt_d = cli_cnt_q;
    peer      = '0;
    status    = StatusDone;

    if ((state_q == S_APPLY) && (key_q != '0)) begin
      case (op_q)
        OpAddClient: begin
          if (cli_full) begin
            status = StatusFull;
          end else begin
            for (int k = 0; k < MaxClients; k++) begin
              cli_ctl[k].load = CliCntW'(k) == cli_cnt_q;
            end
            cli_cnt_d = cli_cnt_q + CliCntW'(1);
          end
        end
        OpAddServer: begin
          if (srv_any) begin
            status = StatusDup;
          end else if (srv_full) begin
            status = StatusFull;
          end else begin
            for (int k = 0; k < MaxServers; k++) begin
              srv_ctl[k].load = SrvCntW'(k) == srv_cnt_q;
            end
            srv_cnt_d = srv_cnt_q + SrvCntW'(1);
          end
        end
        OpDelete: begin
          if (srv_any) begin
            for (int k = 0; k < MaxServers; k++) begin
              srv_ctl[k].shift = srv_tail[k];
            end
            srv_cnt_d = srv_cnt_q - SrvCntW'(1);
          end
          if (cli_any) begin
            for (int k = 0; k < MaxClients; k++) begin
              cli_ctl[k].shift = cli_tail[k];
            end
            cli_cnt_d = cli_cnt_q - CliCntW'(1);
            for (int k = 0; k < MaxServers; k++) begin
              srv_ctl[k].drop = best.val && (best.idx == SrvIdxW'(k));
            end
          end
        end
        OpDispatch: begin
          if (free_any) begin
            for (int k = 0; k < MaxServers; k++) begin
              srv_ctl[k].set_pair = free_first[k];
            end
            peer = disp_id;
          end
        end
        OpGetPeer: begin
          if (srv_any && own_paired) begin
            peer = own_partner;
          end else if (best.val) begin
            peer = best.id;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lvl_q     <= '0;
      srv_cnt_q <= '0;
      cli_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      srv_cnt_q <= srv_cnt_d;
      cli_cnt_q <= cli_cnt_d;
      valid_q   <= state_q == S_APPLY;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start) begin
      op_q  <= req_i.op;
      key_q <= IdBits'(req_i.member_id);
    end
    if (state_q == S_MATCH) begin
      srv_hit_q <= srv_hit;
      free_q    <= srv_free;
      cli_hit_q <= cli_hit;
    end
    if (state_q == S_APPLY) begin
      res_q.peer_id      <= 16'(peer);
      res_q.status       <= status;
      res_q.server_count <= 5'(srv_cnt_d);
      res_q.client_count <= 5'(cli_cnt_d);
    end
  end

  assign busy    = state_q != S_IDLE;
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> rtl/core/ffsp_checker.sv
module ffsp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input ffsp_pkg::req_t req_i,
  input logic           busy,
  input logic           valid_o,
  input ffsp_pkg::res_t res_o
);
  import ffsp_pkg::*;

  // Every accepted word is answered after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Latency) valid_o)
    else $error("result strobe missing after accepted word");

  // The strobe lasts one cycle and the block is free while it shows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!busy ##1 !valid_o))
    else $error("result strobe while busy or held too long");

  // An accepted word keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted word");

  // Counts stay within the table sizes and status is a known code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((res_o.server_count <= 5'(MaxServers))
                 && (res_o.client_count <= 5'(MaxClients))
                 && ((res_o.status == StatusDone) || (res_o.status == StatusFull)
                     || (res_o.status == StatusDup))))
    else $error("result counts or status out of range");

  // Member id zero is never a member, so it finds no peer and raises no error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(start && !busy, Latency) && ($past(req_i.member_id, Latency) == 16'd0))
      |-> ((res_o.peer_id == 16'd0) && (res_o.status == StatusDone)))
    else $error("word with member id zero answered with a peer or error");

endmodule

bind first_free_server_pairing_table_top ffsp_checker u_checker (.*);
